// ----- rtl/core/rrga_pkg.sv -----
package rrga_pkg;

    // Field widths of the request, grant and configuration ports.
    localparam int CLIENT_W = 4;
    localparam int COUNT_W  = 5;

    // Seat count after reset.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd5;

    // Per-client state as stored in the state memory.
    typedef logic [1:0] t_cstate;

    localparam t_cstate ST_THINK  = 2'd0;
    localparam t_cstate ST_HUNGRY = 2'd1;
    localparam t_cstate ST_EAT    = 2'd2;

    // Request function codes.
    localparam logic FN_ACQUIRE = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

endpackage

// ----- rtl/core/rrga_req_if.sv -----
interface rrga_req_if;
    import rrga_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [CLIENT_W-1:0] client;

    modport source (output valid, output func, output client, input ready);
    modport sink   (input valid, input func, input client, output ready);

endinterface

// ----- rtl/core/rrga_grant_if.sv -----
interface rrga_grant_if;
    import rrga_pkg::*;

    logic                valid;
    logic                ready;
    logic [CLIENT_W-1:0] granted_client;
    logic                last_grant;

    modport source (output valid, output granted_client, output last_grant, input ready);
    modport sink   (input valid, input granted_client, input last_grant, output ready);

endinterface

// ----- rtl/core/rrga_ram.sv -----
module rrga_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // One write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/core/ring_resource_grant_arbiter_top.sv -----
// Ring arbiter for clients seated in a circle, where each pair of neighbors
// shares one resource. Clients send transfers on i_req: func selects acquire
// or release, client names the seat. Grants leave on o_grant, one transfer per
// granted client, with last_grant set on the final grant caused by a request.
// A request that causes no grant produces no transfer. The seat count is
// written through i_cfg_we / i_cfg_wdata; the user must write it only while
// the arbiter is idle, as the block itself does not enforce this. Each
// in-range request passes through the write of the requester's new state,
// two reads of neighbor states from the two-port state memory, and the grant
// check, which loads the first grant into the output register. A release
// that grants both neighbors then writes the second grant and loads it into
// the output register. A waiting grant sits in an output register, so the
// next request is taken while it waits; a second grant from the same release
// holds the arbiter until the first grant is taken. When the receiver stalls,
// the arbiter stops in the grant check until the output register frees.
// Reset (synchronous) sets every client to thinking through per-entry valid
// bits, so no clearing pass is needed, and sets the seat count to 5.
module ring_resource_grant_arbiter_top #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rrga_pkg::COUNT_W-1:0] i_cfg_wdata,
    rrga_req_if.sink                    i_req,
    rrga_grant_if.source                o_grant
);
    import rrga_pkg::*;

    localparam int AW = $clog2(MAX_CLIENTS);
    localparam int NW = $clog2(MAX_CLIENTS + 1);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_RD2  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_PEND = 3'd5;

    // Neighbor arithmetic on a ring of n seats.
    function automatic logic [CW-1:0] left_of(input logic [CW-1:0] i, input logic [CW-1:0] n);
        left_of = (i == '0) ? n - CW'(1) : i - CW'(1);
    endfunction

    function automatic logic [CW-1:0] right_of(input logic [CW-1:0] i, input logic [CW-1:0] n);
        right_of = (i + CW'(1) == n) ? '0 : i + CW'(1);
    endfunction

    logic [2:0]             r_state, n_state;
    logic [COUNT_W-1:0]     r_count;
    logic [MAX_CLIENTS-1:0] r_vld, n_vld;
    logic                   r_out_valid, n_out_valid;
    logic [CLIENT_W-1:0]    r_out_id, n_out_id;
    logic                   r_out_last, n_out_last;
    logic                   r_func, n_func;
    logic [AW-1:0]          r_id, n_id;
    logic [AW-1:0]          r_l, n_l;
    logic [AW-1:0]          r_r, n_r;
    logic [AW-1:0]          r_ll, n_ll;
    logic [AW-1:0]          r_rr, n_rr;
    t_cstate                r_sl, n_sl;
    t_cstate                r_sr, n_sr;
    logic                   r_rva;
    logic                   r_rvb;

    logic [CW-1:0] seats;
    logic [CW-1:0] acc_id;
    logic [CW-1:0] acc_l;
    logic [CW-1:0] acc_r;
    logic [CW-1:0] acc_ll;
    logic [CW-1:0] acc_rr;
    logic          in_range;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_cstate       ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    t_cstate       ram_rdata_a;
    t_cstate       ram_rdata_b;
    t_cstate       st_a;
    t_cstate       st_b;

    logic          out_free;
    logic          gl;
    logic          gr;
    t_cstate       sr_eff;
    t_cstate       srr_eff;
    logic          any_grant;
    logic          two_grant;
    logic [AW-1:0] first_id;

    // Effective seat count: zero acts as one, large values clip.
    always_comb begin
        if (r_count == '0) begin
            seats = CW'(1);
        end else if (CW'(r_count) > CW'(MAX_CLIENTS)) begin
            seats = CW'(MAX_CLIENTS);
        end else begin
            seats = CW'(r_count);
        end
    end

    assign acc_id   = CW'(i_req.client);
    assign in_range = (acc_id < seats);
    assign acc_l    = left_of(acc_id, seats);
    assign acc_r    = right_of(acc_id, seats);
    assign acc_ll   = left_of(acc_l, seats);
    assign acc_rr   = right_of(acc_r, seats);

    // State memory: first read pair fetches the neighbors, second pair the
    // neighbors' outer neighbors.
    assign ram_raddr_a = (r_state == S_RD1) ? r_l : r_ll;
    assign ram_raddr_b = (r_state == S_RD1) ? r_r : r_rr;

    rrga_ram #(
        .WIDTH($bits(t_cstate)),
        .DEPTH(MAX_CLIENTS)
    ) u_state_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(ram_raddr_a),
        .i_raddr_b(ram_raddr_b),
        .o_rdata_a(ram_rdata_a),
        .o_rdata_b(ram_rdata_b)
    );

    // An entry never written since reset reads as thinking.
    assign st_a = r_rva ? ram_rdata_a : ST_THINK;
    assign st_b = r_rvb ? ram_rdata_b : ST_THINK;

    // Grant check. For a release the requester is already thinking, so only
    // the outer neighbors and the effect of the left grant matter.
    always_comb begin
        gl      = 1'b0;
        gr      = 1'b0;
        sr_eff  = r_sr;
        srr_eff = st_b;
        if (r_func == FN_ACQUIRE) begin
            any_grant = (r_sl != ST_EAT) && (r_sr != ST_EAT);
            two_grant = 1'b0;
            first_id  = r_id;
        end else begin
            gl = (r_sl == ST_HUNGRY) && (st_a != ST_EAT);
            if (gl && (r_r == r_l)) begin
                sr_eff = ST_EAT;
            end
            if (gl && (r_rr == r_l)) begin
                srr_eff = ST_EAT;
            end
            gr        = (sr_eff == ST_HUNGRY) && (srr_eff != ST_EAT);
            any_grant = gl || gr;
            two_grant = gl && gr;
            first_id  = gl ? r_l : r_r;
        end
    end

    assign out_free = !r_out_valid || o_grant.ready;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && !o_grant.ready;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;
        n_func      = r_func;
        n_id        = r_id;
        n_l         = r_l;
        n_r         = r_r;
        n_ll        = r_ll;
        n_rr        = r_rr;
        n_sl        = r_sl;
        n_sr        = r_sr;
        ram_we      = 1'b0;
        ram_waddr   = r_r;
        ram_wdata   = ST_EAT;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && in_range) begin
                    ram_we           = 1'b1;
                    ram_waddr        = acc_id[AW-1:0];
                    ram_wdata        = (i_req.func == FN_ACQUIRE) ? ST_HUNGRY : ST_THINK;
                    n_vld[acc_id[AW-1:0]] = 1'b1;
                    n_func           = i_req.func;
                    n_id             = acc_id[AW-1:0];
                    n_l              = acc_l[AW-1:0];
                    n_r              = acc_r[AW-1:0];
                    n_ll             = acc_ll[AW-1:0];
                    n_rr             = acc_rr[AW-1:0];
                    n_state          = S_RD1;
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                n_sl    = st_a;
                n_sr    = st_b;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!any_grant) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    ram_we      = 1'b1;
                    ram_waddr   = first_id;
                    n_out_valid = 1'b1;
                    n_out_id    = CLIENT_W'(first_id);
                    n_out_last  = !two_grant;
                    n_state     = two_grant ? S_WR2 : S_IDLE;
                end
            end
            S_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_r;
                n_state   = S_PEND;
            end
            S_PEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = CLIENT_W'(r_r);
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= COUNT_RESET;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
        r_func     <= n_func;
        r_id       <= n_id;
        r_l        <= n_l;
        r_r        <= n_r;
        r_ll       <= n_ll;
        r_rr       <= n_rr;
        r_sl       <= n_sl;
        r_sr       <= n_sr;
        r_rva      <= r_vld[ram_raddr_a];
        r_rvb      <= r_vld[ram_raddr_b];
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_grant.valid          = r_out_valid;
    assign o_grant.granted_client = r_out_id;
    assign o_grant.last_grant     = r_out_last;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rrga_pkg::*;

    localparam int MAX_SEATS = 16;
    // Cycles a request can still be in flight after the last grant has left.
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [CLIENT_W-1:0] granted_client;
        logic                last_grant;
    } t_grant_rec;

    // Tracks seat states, predicts grants per request and checks them in order.
    class grant_scoreboard;
        t_cstate            seat_state[MAX_SEATS];
        logic [COUNT_W-1:0] seat_count;
        t_grant_rec         pending_grants[$];
        int unsigned        requests_seen;
        int unsigned        ignored_requests;
        int unsigned        grants_checked;
        int unsigned        double_grants;
        int unsigned        errors;

        function new();
            foreach (seat_state[i]) seat_state[i] = ST_THINK;
            seat_count       = COUNT_RESET;
            requests_seen    = 0;
            ignored_requests = 0;
            grants_checked   = 0;
            double_grants    = 0;
            errors           = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            seat_count = value;
        endfunction

        // A count of zero acts as one seat; counts above the ring size saturate.
        function int unsigned seats();
            if (seat_count == 0) return 1;
            if (seat_count > MAX_SEATS) return MAX_SEATS;
            return 32'(seat_count);
        endfunction

        function int unsigned pending();
            return pending_grants.size();
        endfunction

        // Grants seat i when it is hungry and neither neighbor is eating.
        function bit try_grant(int unsigned i, int unsigned n);
            int unsigned l;
            int unsigned r;
            l = (i + n - 1) % n;
            r = (i + 1) % n;
            if (seat_state[i] == ST_HUNGRY && seat_state[l] != ST_EAT &&
                seat_state[r] != ST_EAT) begin
                seat_state[i] = ST_EAT;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Applies one accepted request and queues the grants it causes.
        function void note_request(logic func, logic [CLIENT_W-1:0] client);
            int unsigned         n;
            int unsigned         l;
            int unsigned         r;
            logic [CLIENT_W-1:0] hits[$];
            t_grant_rec          rec;
            n = seats();
            requests_seen++;
            if (client >= n) begin
                ignored_requests++;
                return;
            end
            if (func == FN_ACQUIRE) begin
                seat_state[client] = ST_HUNGRY;
                if (try_grant(client, n)) hits.push_back(client);
            end else begin
                l = (client + n - 1) % n;
                r = (client + 1) % n;
                seat_state[client] = ST_THINK;
                if (try_grant(l, n)) hits.push_back(l[CLIENT_W-1:0]);
                if (try_grant(r, n)) hits.push_back(r[CLIENT_W-1:0]);
            end
            if (hits.size() == 2) double_grants++;
            foreach (hits[k]) begin
                rec.granted_client = hits[k];
                rec.last_grant     = (k == hits.size() - 1);
                pending_grants.push_back(rec);
            end
        endfunction

        // Compares one grant transfer with the oldest prediction.
        function void check_grant(logic [CLIENT_W-1:0] granted, logic last);
            t_grant_rec exp_rec;
            if (pending_grants.size() == 0) begin
                $error("grant transfer for client %0d with no grant predicted", granted);
                errors++;
                return;
            end
            exp_rec = pending_grants.pop_front();
            grants_checked++;
            if (granted !== exp_rec.granted_client) begin
                $error("granted_client: expected %0d, actual %0d",
                       exp_rec.granted_client, granted);
                errors++;
            end
            if (last !== exp_rec.last_grant) begin
                $error("last_grant: expected %0d, actual %0d", exp_rec.last_grant, last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    bit                 no_idle;
    int unsigned        count_writes;

    grant_scoreboard sb;

    rrga_req_if   req_bus ();
    rrga_grant_if grant_bus ();

    ring_resource_grant_arbiter_top #(
        .MAX_CLIENTS(MAX_SEATS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_bus.sink),
        .o_grant    (grant_bus.source)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watch both channels at every rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                sb.note_request(req_bus.func, req_bus.client);
            end
            if (grant_bus.valid && grant_bus.ready) begin
                sb.check_grant(grant_bus.granted_client, grant_bus.last_grant);
            end
        end
    end

    // Grant receiver: unless no_idle is set, holds ready low for a random stall before each transfer.
    initial begin
        int stall;
        grant_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : int'($urandom_range(0, 11));
            if (stall > 0) begin
                grant_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            grant_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!grant_bus.valid) @(posedge i_clk);
        end
    end

    // Offers one request after a random gap and waits for its transfer.
    task automatic send_request(input logic func, input logic [CLIENT_W-1:0] client);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 11));
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.func   <= func;
        req_bus.client <= client;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    // Stops sending and waits until every predicted grant has arrived.
    task automatic drain();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the seat count; only called once the arbiter is idle.
    task automatic write_count(input logic [COUNT_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_count(value);
        count_writes++;
    endtask

    // Main stimulus.
    initial begin
        logic [COUNT_W-1:0]  phase_counts[12];
        logic [CLIENT_W-1:0] client;
        logic                func;
        int unsigned         n;
        int unsigned         per_phase;
        int unsigned         done_in_phase;
        bit                  paused;

        sb           = new();
        count_writes = 0;
        no_idle      = 1'b0;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_bus.valid   <= 1'b0;
        req_bus.func    <= FN_ACQUIRE;
        req_bus.client  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset count of five: a release that grants both neighbors.
        send_request(FN_ACQUIRE, 4'd0);
        send_request(FN_ACQUIRE, 4'd1);
        send_request(FN_ACQUIRE, 4'd4);
        send_request(FN_RELEASE, 4'd0);
        // Acquire while eating is granted again; release while thinking.
        send_request(FN_ACQUIRE, 4'd1);
        send_request(FN_RELEASE, 4'd3);
        // Clients past the ring are ignored.
        send_request(FN_ACQUIRE, 4'd7);
        send_request(FN_RELEASE, 4'd15);
        send_request(FN_RELEASE, 4'd1);
        send_request(FN_RELEASE, 4'd4);

        // A single seat is its own neighbor on both sides.
        write_count(5'd1);
        send_request(FN_ACQUIRE, 4'd0);
        send_request(FN_RELEASE, 4'd0);
        send_request(FN_ACQUIRE, 4'd3);

        // Two seats share both neighbors, so a release grants once.
        write_count(5'd2);
        send_request(FN_ACQUIRE, 4'd0);
        send_request(FN_ACQUIRE, 4'd1);
        send_request(FN_RELEASE, 4'd0);
        send_request(FN_RELEASE, 4'd1);

        // Full ring, then the saturating counts at both ends of the field.
        write_count(5'd16);
        send_request(FN_ACQUIRE, 4'd15);
        send_request(FN_ACQUIRE, 4'd14);
        send_request(FN_RELEASE, 4'd15);
        send_request(FN_RELEASE, 4'd14);
        write_count(5'd0);
        send_request(FN_ACQUIRE, 4'd0);
        send_request(FN_ACQUIRE, 4'd1);
        write_count(5'd31);
        send_request(FN_ACQUIRE, 4'd15);

        // Random phases: each sets a count, then sends mostly in-ring requests.
        phase_counts = '{5'd5, 5'd16, 5'd3, 5'd2, 5'd1, 5'd0,
                         5'd31, 5'd7, 5'd17, 5'd0, 5'd16, 5'd4};
        phase_counts[9] = COUNT_W'($urandom_range(0, 31));
        per_phase = 83;
        foreach (phase_counts[p]) begin
            write_count(phase_counts[p]);
            no_idle       = ($urandom_range(0, 3) == 0);
            done_in_phase = 0;
            paused        = 1'b0;
            while (done_in_phase < per_phase) begin
                n = sb.seats();
                if (n < MAX_SEATS && $urandom_range(0, 99) < 12) begin
                    client = CLIENT_W'($urandom_range(n, MAX_SEATS - 1));
                end else begin
                    client = CLIENT_W'($urandom_range(0, n - 1));
                    done_in_phase++;
                end
                func = ($urandom_range(0, 99) < 55) ? FN_ACQUIRE : FN_RELEASE;
                // Hold off mid-phase until the arbiter has emptied.
                if (!paused && done_in_phase == per_phase / 2 &&
                    (p == 0 || $urandom_range(0, 3) == 0)) begin
                    drain();
                    paused = 1'b1;
                end
                send_request(func, client);
            end
        end

        drain();
        $display("Covered %0d requests (%0d outside the ring) over %0d seat-count writes.",
                 sb.requests_seen, sb.ignored_requests, count_writes);
        $display("Checked %0d grants, %0d releases granted both neighbors, %0d errors.",
                 sb.grants_checked, sb.double_grants, sb.errors);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("Run stopped by the watchdog with %0d grants outstanding.", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
